// File: rtl/wsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared constants, result codes and the command type that the parser hands
// through the queue to the output stage.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [1:0] KIND_EMPTY_END = 2'd1;
	localparam logic [1:0] KIND_PONG      = 2'd2;
	localparam logic [1:0] KIND_ERROR     = 2'd3;

	// Frame opcodes that the parser acts on.
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_BIN  = 4'h2;
	localparam logic [3:0] OP_PING = 4'h9;

	// Seven-bit length codes that announce an extended length field.
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;
	localparam logic [3:0] LEN16_BYTES = 4'd2;
	localparam logic [3:0] LEN64_BYTES = 4'd8;
	localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

	// Configuration registers.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_MODE = 1'b1;
	localparam logic [31:0] MAX_SIZE_RESET = 32'd33554432;

	// Queue between the parser and the output stage.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// One result as produced by the parser; the payload byte is still masked.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  raw_byte;
		logic [7:0]  key_byte;
		logic [3:0]  opcode;
		logic        last;
		logic [31:0] length;
	} cmd_t;

endpackage

// File: rtl/wsfd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one connection byte per request.
// ----------------------------------------------------------------------------
interface wsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/wsfd_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one decoded result per request.
// ----------------------------------------------------------------------------
interface wsfd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [3:0]  message_opcode;
	logic        message_last;
	logic [31:0] message_length;

	modport source (output valid, output kind, output payload_byte,
		output message_opcode, output message_last, output message_length,
		input ready);
	modport sink (input valid, input kind, input payload_byte,
		input message_opcode, input message_last, input message_length,
		output ready);
endinterface

// File: rtl/wsfd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface wsfd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wsfd_pkg::CFG_IDX_W-1:0]  index;
	logic [31:0]                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/wsfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser (front end)
// Accepts one received byte per cycle while the queue has room, tracks frame
// layout, checks the message length limit, queues one command per result.
// ----------------------------------------------------------------------------
module wsfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	wsfd_byte_if.sink         rx,
	wsfd_cfg_if.sink          cfg,
	input  logic              q_full,
	output logic              push,
	output wsfd_pkg::cmd_t    cmd
);

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  fop_q, fop_d;
	logic        masked_q, masked_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  idx_q, idx_d;
	logic [31:0] acc_q, acc_d;
	logic [3:0]  mop_q, mop_d;
	logic        closed_q, closed_d;
	logic [31:0] max_q;
	logic        client_q;

	logic        accept;
	logic [7:0]  b;
	logic [63:0] ld_len;
	logic [31:0] room;
	logic        too_big;
	logic        known;
	logic        start_payload;
	logic        err;
	logic [3:0]  mop_upd;
	logic [7:0]  key_byte;
	logic [31:0] acc_inc;

	// Bytes are taken whenever the queue has room for a result.
	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= wsfd_pkg::MAX_SIZE_RESET;
			client_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				wsfd_pkg::CFG_MAX_SIZE:    max_q <= cfg.data;
				wsfd_pkg::CFG_CLIENT_MODE: client_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Length as it stands once this byte is folded in, and the limit check.
	assign ld_len  = (phase_q == PH_EXTLEN) ? {len_q[55:0], b} : {57'd0, b[6:0]};
	assign room    = max_q - acc_q;
	assign too_big = (acc_q >= max_q) || (ld_len >= {32'd0, room});
	assign mop_upd = ((mop_q == wsfd_pkg::OP_CONT) && (fop_q != wsfd_pkg::OP_CONT))
		? fop_q : mop_q;
	assign acc_inc = acc_q + 32'd1;

	// Mask key byte for the current payload position, first key byte first.
	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Next-state logic of the parser.
	always_comb begin
		phase_d  = phase_q;
		fin_d    = fin_q;
		fop_d    = fop_q;
		masked_d = masked_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		key_d    = key_q;
		idx_d    = idx_q;
		acc_d    = acc_q;
		mop_d    = mop_q;
		closed_d = closed_q;
		known         = 1'b0;
		start_payload = 1'b0;
		err           = 1'b0;
		push = 1'b0;
		cmd  = '0;

		if (accept && !closed_q) begin
			case (phase_q)
				PH_HDR0: begin
					fin_d   = b[7];
					fop_d   = b[3:0];
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					masked_d = b[7];
					phase_d  = PH_HDR0;
					if (fop_q == wsfd_pkg::OP_PING) begin
						push     = 1'b1;
						cmd.kind = wsfd_pkg::KIND_PONG;
					end else if (fop_q == wsfd_pkg::OP_CONT || fop_q == wsfd_pkg::OP_TEXT ||
						fop_q == wsfd_pkg::OP_BIN) begin
						if (!client_q && !b[7]) begin
							err = 1'b1;
						end else if (b[6:0] == wsfd_pkg::LEN16_CODE) begin
							len_d   = '0;
							cnt_d   = wsfd_pkg::LEN16_BYTES;
							phase_d = PH_EXTLEN;
						end else if (b[6:0] == wsfd_pkg::LEN64_CODE) begin
							len_d   = '0;
							cnt_d   = wsfd_pkg::LEN64_BYTES;
							phase_d = PH_EXTLEN;
						end else begin
							len_d = ld_len;
							known = 1'b1;
						end
					end
				end
				PH_EXTLEN: begin
					len_d = ld_len;
					cnt_d = cnt_q - 4'd1;
					known = (cnt_q == 4'd1);
				end
				PH_MASK: begin
					key_d = {key_q[23:0], b};
					cnt_d = cnt_q - 4'd1;
					start_payload = (cnt_q == 4'd1);
				end
				PH_PAYLOAD: begin
					acc_d = acc_inc;
					idx_d = idx_q + 2'd1;
					len_d = len_q - 64'd1;
					push  = 1'b1;
					cmd.kind     = wsfd_pkg::KIND_PAYLOAD;
					cmd.raw_byte = b;
					cmd.key_byte = key_byte;
					cmd.opcode   = mop_q;
					if (len_q == 64'd1) begin
						phase_d = PH_HDR0;
						if (fin_q) begin
							cmd.last   = 1'b1;
							cmd.length = acc_inc;
							acc_d = '0;
							mop_d = wsfd_pkg::OP_CONT;
						end
					end
				end
				default: phase_d = PH_HDR0;
			endcase

			// Frame length is complete: check the limit, then mask key or payload.
			if (known) begin
				if (too_big) begin
					err = 1'b1;
				end else begin
					mop_d = mop_upd;
					key_d = '0;
					if (masked_d) begin
						phase_d = PH_MASK;
						cnt_d   = wsfd_pkg::MASK_KEY_BYTES;
					end else begin
						start_payload = 1'b1;
					end
				end
			end

			// Payload start; an empty final frame ends the message at once.
			if (start_payload) begin
				idx_d = '0;
				if (len_d != 64'd0) begin
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_HDR0;
					if (fin_q) begin
						push       = 1'b1;
						cmd.kind   = wsfd_pkg::KIND_EMPTY_END;
						cmd.opcode = mop_d;
						cmd.last   = 1'b1;
						cmd.length = acc_q;
						acc_d = '0;
						mop_d = wsfd_pkg::OP_CONT;
					end
				end
			end

			// Protocol or size violation closes the block until reset.
			if (err) begin
				closed_d = 1'b1;
				phase_d  = PH_HDR0;
				push     = 1'b1;
				cmd      = '0;
				cmd.kind = wsfd_pkg::KIND_ERROR;
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			fop_q    <= '0;
			masked_q <= 1'b0;
			cnt_q    <= '0;
			len_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			acc_q    <= '0;
			mop_q    <= '0;
			closed_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			fop_q    <= fop_d;
			masked_q <= masked_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
			acc_q    <= acc_d;
			mop_q    <= mop_d;
			closed_q <= closed_d;
		end
	end

	// Once closed, the block stays closed and produces nothing more.
	assert property (@(posedge clk) disable iff (!arst_n) closed_q |=> closed_q)
		else $error("closed flag dropped without reset");
	assert property (@(posedge clk) disable iff (!arst_n) closed_q |-> !push)
		else $error("result pushed while closed");

endmodule

// File: rtl/wsfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO between the parser and the output stage so each side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module wsfd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  wsfd_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output wsfd_pkg::cmd_t        head,
	output logic                  full,
	output logic                  empty
);

	localparam logic [wsfd_pkg::QPTR_W-1:0] LAST_PTR = wsfd_pkg::QPTR_W'(wsfd_pkg::QDEPTH - 1);

	wsfd_pkg::cmd_t                 mem_q [wsfd_pkg::QDEPTH];
	logic [wsfd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [wsfd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [wsfd_pkg::QCNT_W-1:0]    count_q;

	assign full  = (count_q == wsfd_pkg::QCNT_W'(wsfd_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> (!full || pop))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue underflow");

endmodule

// File: rtl/wsfd_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output stage (back end)
// Takes commands from the queue, unmasks payload bytes and holds each result
// in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module wsfd_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  wsfd_pkg::cmd_t    head,
	output logic              pop,
	wsfd_res_if.source        res
);

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [3:0]  opcode_q;
	logic        last_q;
	logic [31:0] length_q;

	// Refill the output register when it is empty or being taken.
	assign pop = !q_empty && (!valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload, unmasked on the way in.
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head.kind;
			byte_q   <= head.raw_byte ^ head.key_byte;
			opcode_q <= head.opcode;
			last_q   <= head.last;
			length_q <= head.length;
		end
	end

	assign res.valid          = valid_q;
	assign res.kind           = kind_q;
	assign res.payload_byte   = byte_q;
	assign res.message_opcode = opcode_q;
	assign res.message_last   = last_q;
	assign res.message_length = length_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind != wsfd_pkg::KIND_PAYLOAD) |-> (res.payload_byte == 8'd0))
		else $error("non-payload result carries a data byte");

endmodule

// File: rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser: header, extended length, mask key and payload
// unmasking, with message accounting, pong requests and error close.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while the command queue
// has room and keeps that rate for any mix of frames, since each byte updates
// the parser state as it is taken. A result reaches res through the two-entry
// command queue and then the output register.
// The byte input stalls only while that queue is full, which happens only
// when the result consumer holds res.ready low. Configuration writes are
// always taken and must be made while no request is in flight. After an
// error close every byte is still taken but ignored until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	wsfd_byte_if.sink   rx,
	wsfd_res_if.source  res,
	wsfd_cfg_if.sink    cfg
);

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	wsfd_pkg::cmd_t    push_cmd;
	wsfd_pkg::cmd_t    head;

	// Front end: parse bytes into result commands.
	wsfd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// Decoupling queue.
	wsfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back end: unmask and present results.
	wsfd_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.res     (res)
	);

endmodule
